### rtl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and constants for the sorted key table: item layouts, the
// entry held by each cell, cell control and controller states.
// ----------------------------------------------------------------------------
package skt_pkg;

	localparam int KEY_BITS    = 32;
	localparam int HANDLE_BITS = 32;
	localparam int CMD_BITS    = 2;
	localparam int STATUS_BITS = 2;
	localparam int COUNT_BITS  = 5;

	typedef logic signed [KEY_BITS-1:0] skt_key_t;
	typedef logic [HANDLE_BITS-1:0]     skt_handle_t;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_INSERT = 2'd0,
		CMD_FIND   = 2'd1,
		CMD_REMOVE = 2'd2
	} skt_cmd_t;

	typedef enum logic [STATUS_BITS-1:0] {
		STATUS_DONE    = 2'd0,
		STATUS_DUP     = 2'd1,
		STATUS_MISSING = 2'd2,
		STATUS_FULL    = 2'd3
	} skt_status_t;

	typedef struct packed {
		logic [CMD_BITS-1:0] command;
		skt_key_t            search_key;
		skt_handle_t         entry_handle;
	} skt_req_t;

	typedef struct packed {
		logic [STATUS_BITS-1:0] status;
		skt_handle_t            handle_out;
		logic [COUNT_BITS-1:0]  entry_count;
	} skt_rsp_t;

	// Contents of one cell as seen by its neighbors.
	typedef struct packed {
		logic        valid;
		skt_key_t    key;
		skt_handle_t handle;
	} skt_entry_t;

	// Control broadcast from the controller to every cell.
	typedef struct packed {
		logic capture;
		logic insert;
		logic remove;
	} skt_cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE    = 2'd0,
		ST_COMPARE = 2'd1,
		ST_APPLY   = 2'd2
	} skt_state_t;

endpackage

### rtl/skt_cell.sv
// ----------------------------------------------------------------------------
// skt_cell
// One slot of the ordered chain. Compares its entry against the broadcast
// key, then keeps its entry, loads the new one or takes a neighbor's.
// ----------------------------------------------------------------------------
module skt_cell
	import skt_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  skt_cell_ctl_t ctl,
	input  skt_key_t      key_s1,
	input  skt_handle_t   handle_s1,
	input  skt_entry_t    left_ent,
	input  logic          left_lt,
	input  skt_entry_t    right_ent,
	output skt_entry_t    ent,
	output logic          lt,
	output logic          eq,
	output skt_handle_t   hit_handle
);

	logic        valid_q;
	skt_key_t    key_q;
	skt_handle_t handle_q;
	logic        lt_q;
	logic        eq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			lt_q    <= 1'b0;
			eq_q    <= 1'b0;
		end else begin
			if (ctl.capture) begin
				lt_q <= valid_q && (key_q < key_s1);
				eq_q <= valid_q && (key_q == key_s1);
			end
			if (ctl.insert && !lt_q) begin
				// first cell not below the key takes the new entry
				valid_q <= left_lt ? 1'b1 : left_ent.valid;
			end else if (ctl.remove && !lt_q) begin
				valid_q <= right_ent.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.insert && !lt_q) begin
			if (left_lt) begin
				key_q    <= key_s1;
				handle_q <= handle_s1;
			end else begin
				key_q    <= left_ent.key;
				handle_q <= left_ent.handle;
			end
		end else if (ctl.remove && !lt_q) begin
			key_q    <= right_ent.key;
			handle_q <= right_ent.handle;
		end
	end

	assign ent.valid  = valid_q;
	assign ent.key    = key_q;
	assign ent.handle = handle_q;
	assign lt         = lt_q;
	assign eq         = eq_q;
	assign hit_handle = eq_q ? handle_q : '0;

endmodule

### rtl/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table
// Ordered table of signed keys with payload handles, held in a cell chain.
// ----------------------------------------------------------------------------
// Each item passes a compare state and then an apply state: in the compare
// state every cell compares its stored key with the item's key at once, in
// the apply state the chain shifts one place (right for an insert, left for
// a remove) and the result is registered. With the result side taking
// results as they come, a new item is accepted as the previous one applies;
// a held result only delays the next apply. Up to CAPACITY entries are kept
// in ascending signed key order; no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module sorted_key_table
	import skt_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  skt_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output skt_rsp_t rsp
);

	localparam int CW = $clog2(CAPACITY + 1);

	skt_state_t    state_q, state_d;
	skt_cell_ctl_t ctl;
	logic          accept;
	logic          out_free;
	logic          commit;

	logic [CMD_BITS-1:0] cmd_s1;
	skt_key_t            key_s1;
	skt_handle_t         handle_s1;

	logic [CW-1:0] fill_count_q;
	logic [CW-1:0] fill_count_d;
	logic          rsp_valid_q;
	skt_rsp_t      rsp_q;

	skt_entry_t  ent        [CAPACITY];
	skt_entry_t  left_ent   [CAPACITY];
	skt_entry_t  right_ent  [CAPACITY];
	logic        left_lt    [CAPACITY];
	logic        lt         [CAPACITY];
	logic        eq         [CAPACITY];
	skt_handle_t hit_handle [CAPACITY];

	logic        hit;
	skt_handle_t found_handle;
	logic        full;
	logic        insert_do;
	logic        remove_do;
	skt_rsp_t    result;
	logic [CW+COUNT_BITS-1:0] count_ext;

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign accept   = req_valid && !req_stall;
	assign commit   = (state_q == ST_APPLY) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = ST_COMPARE;
				end
			end
			ST_COMPARE: begin
				state_d = ST_APPLY;
			end
			ST_APPLY: begin
				if (out_free) begin
					// next item may enter while this one retires
					req_stall = 1'b0;
					state_d   = req_valid ? ST_COMPARE : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= req.command;
			key_s1    <= req.search_key;
			handle_s1 <= req.entry_handle;
		end
	end

	// At most one cell matches, so an OR picks its handle.
	always_comb begin
		hit          = 1'b0;
		found_handle = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit          = hit | eq[i];
			found_handle = found_handle | hit_handle[i];
		end
	end

	assign full      = (fill_count_q == CW'(CAPACITY));
	assign insert_do = (cmd_s1 == CMD_INSERT) && !hit && !full;
	assign remove_do = (cmd_s1 == CMD_REMOVE) && hit;

	always_comb begin
		fill_count_d = fill_count_q;
		if (insert_do) begin
			fill_count_d = fill_count_q + CW'(1);
		end else if (remove_do) begin
			fill_count_d = fill_count_q - CW'(1);
		end
	end

	assign count_ext = {{COUNT_BITS{1'b0}}, fill_count_d};

	always_comb begin
		result.status      = STATUS_MISSING;
		result.handle_out  = '0;
		result.entry_count = count_ext[COUNT_BITS-1:0];
		case (cmd_s1)
			CMD_INSERT: begin
				if (hit) begin
					result.status = STATUS_DUP;
				end else if (full) begin
					result.status = STATUS_FULL;
				end else begin
					result.status = STATUS_DONE;
				end
			end
			CMD_FIND, CMD_REMOVE: begin
				if (hit) begin
					result.status     = STATUS_DONE;
					result.handle_out = found_handle;
				end
			end
			default: begin
				result.status = STATUS_MISSING;
			end
		endcase
	end

	assign ctl.capture = (state_q == ST_COMPARE);
	assign ctl.insert  = commit && insert_do;
	assign ctl.remove  = commit && remove_do;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_count_q <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (commit) begin
				fill_count_q <= fill_count_d;
			end
			rsp_valid_q <= commit || (rsp_valid_q && rsp_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign left_ent[i] = '0;
			assign left_lt[i]  = 1'b1;
		end else begin : g_link
			assign left_ent[i] = ent[i-1];
			assign left_lt[i]  = lt[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_ent[i] = '0;
		end else begin : g_next
			assign right_ent[i] = ent[i+1];
		end

		skt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.key_s1     (key_s1),
			.handle_s1  (handle_s1),
			.left_ent   (left_ent[i]),
			.left_lt    (left_lt[i]),
			.right_ent  (right_ent[i]),
			.ent        (ent[i]),
			.lt         (lt[i]),
			.eq         (eq[i]),
			.hit_handle (hit_handle[i])
		);
	end

endmodule
